>>> rtl/core/mwsm_pkg.sv
// Shared widths, register codes and inter-stage payload types of the mecanum wheel mixer.
package mwsm_pkg;

  // Field and register widths
  localparam int SPEED_W    = 16;
  localparam int CFG_W      = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int FRAC_BITS  = 11;
  localparam int FRAC_MASK  = (1 << FRAC_BITS) - 1;
  localparam int NUM_WHEELS = 4;

  // Derived datapath widths
  localparam int CMP_W   = ((SPEED_W > CFG_W) ? SPEED_W : CFG_W) + 1;
  localparam int PROD_W  = SPEED_W + CFG_W;
  localparam int ROT_W   = PROD_W - FRAC_BITS;
  localparam int WHEEL_W = ((SPEED_W + 1 > ROT_W) ? SPEED_W + 1 : ROT_W) + 1;
  localparam int MAG_W   = WHEEL_W;
  localparam int NUM_W   = MAG_W + CFG_W;
  localparam int QUO_W   = CFG_W;
  localparam int REM_W   = MAG_W + 1;

  // Divider: quotient bits retired per pipeline stage
  localparam int DIV_STEP   = 3;
  localparam int DIV_STAGES = QUO_W / DIV_STEP;

  // Output saturation bound
  localparam logic signed [WHEEL_W-1:0] SPEED_MAX =
    WHEEL_W'((64'd1 << (SPEED_W - 1)) - 64'd1);

  // Register reset values
  localparam logic [CFG_W-1:0] RST_MAX_LATERAL = CFG_W'(4096);
  localparam logic [CFG_W-1:0] RST_MAX_FORWARD = CFG_W'(4096);
  localparam logic [CFG_W-1:0] RST_MAX_WHEEL   = CFG_W'(8192);
  localparam logic [CFG_W-1:0] RST_CENTER_DIST = CFG_W'(909);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_LATERAL = 2'd0,
    REG_MAX_FORWARD = 2'd1,
    REG_MAX_WHEEL   = 2'd2,
    REG_CENTER_DIST = 2'd3
  } cfg_idx_t;

  // Mixed wheel speeds, signed
  typedef struct packed {
    logic [NUM_WHEELS-1:0][WHEEL_W-1:0] wheel;
  } mix_t;

  // Divider operands: numerators, magnitudes, signs, peak divisor
  typedef struct packed {
    logic [NUM_WHEELS-1:0][NUM_W-1:0] num;
    logic [NUM_WHEELS-1:0][MAG_W-1:0] mag;
    logic [NUM_WHEELS-1:0]            neg;
    logic [MAG_W-1:0]                 peak;
    logic                             scaled;
  } num_t;

  // Divider results
  typedef struct packed {
    logic [NUM_WHEELS-1:0][QUO_W-1:0] quo;
    logic [NUM_WHEELS-1:0][MAG_W-1:0] mag;
    logic [NUM_WHEELS-1:0]            neg;
    logic                             scaled;
  } res_t;

endpackage

>>> rtl/core/mecanum_wheel_speed_mixer.sv
// Top level of the mecanum wheel speed mixer: registers, pipeline and output stage.
//
// Turns a chassis command (lateral, forward, yaw rate; signed Q4.11) into four
// wheel set-points, scaling all wheels by limit/peak (truncated toward zero) when
// the largest wheel magnitude exceeds max_wheel_limit, and flagging that in
// was_scaled. The block takes one command per clock while in_ready is high and
// passes each one through these stages: two stages clamp and mix, two find the
// peak and form the numerators, five divider stages retire three quotient bits
// each, and one stage applies sign and saturation. Valid bits travel with the
// data and any empty stage is filled while the output is stalled. Registers
// are read live by the pipeline, so a write applies to commands transferred
// after it once the pipeline has drained.
module mecanum_wheel_speed_mixer import mwsm_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  // command channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [SPEED_W-1:0] in_lateral_cmd,
  input  logic signed [SPEED_W-1:0] in_forward_cmd,
  input  logic signed [SPEED_W-1:0] in_yaw_rate_cmd,
  // wheel channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [SPEED_W-1:0] out_wheel_front_left,
  output logic signed [SPEED_W-1:0] out_wheel_front_right,
  output logic signed [SPEED_W-1:0] out_wheel_rear_right,
  output logic signed [SPEED_W-1:0] out_wheel_rear_left,
  output logic                      out_was_scaled,
  // register writes
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data
);

  logic [CFG_W-1:0] max_lat_r, max_fwd_r, max_wheel_r, ctr_dist_r;

  logic mix_vld, mix_rdy;
  mix_t mix_data;
  logic num_vld, num_rdy;
  num_t num_data;
  logic res_vld, res_rdy;
  res_t res_data;

  logic                             out_valid_r;
  logic [NUM_WHEELS-1:0][SPEED_W-1:0] wheel_r, wheel_nxt;
  logic                             scaled_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_lat_r   <= RST_MAX_LATERAL;
      max_fwd_r   <= RST_MAX_FORWARD;
      max_wheel_r <= RST_MAX_WHEEL;
      ctr_dist_r  <= RST_CENTER_DIST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_MAX_LATERAL: max_lat_r   <= cfg_data;
        REG_MAX_FORWARD: max_fwd_r   <= cfg_data;
        REG_MAX_WHEEL:   max_wheel_r <= cfg_data;
        REG_CENTER_DIST: ctr_dist_r  <= cfg_data;
      endcase
    end
  end

  // Clamp and mix
  mwsm_mix u_mix (
    .clk        (clk),
    .rst_n      (rst_n),
    .vld_i      (in_valid),
    .rdy_o      (in_ready),
    .lat_i      (in_lateral_cmd),
    .fwd_i      (in_forward_cmd),
    .yaw_i      (in_yaw_rate_cmd),
    .max_lat_i  (max_lat_r),
    .max_fwd_i  (max_fwd_r),
    .ctr_dist_i (ctr_dist_r),
    .vld_o      (mix_vld),
    .rdy_i      (mix_rdy),
    .mix_o      (mix_data)
  );

  // Peak and numerators
  mwsm_peak u_peak (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (mix_vld),
    .rdy_o (mix_rdy),
    .mix_i (mix_data),
    .lim_i (max_wheel_r),
    .vld_o (num_vld),
    .rdy_i (num_rdy),
    .num_o (num_data)
  );

  // Desaturation divider
  mwsm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (num_vld),
    .rdy_o (num_rdy),
    .num_i (num_data),
    .vld_o (res_vld),
    .rdy_i (res_rdy),
    .res_o (res_data)
  );

  assign res_rdy = !out_valid_r || out_ready;

  // Output stage: pick scaled or raw magnitude, restore sign, saturate
  always_comb begin
    logic signed [WHEEL_W-1:0] val;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      if (res_data.scaled) begin
        val = WHEEL_W'(res_data.quo[i]);
      end else begin
        val = WHEEL_W'(res_data.mag[i]);
      end
      if (res_data.neg[i]) begin
        val = -val;
      end
      if (val > SPEED_MAX) begin
        wheel_nxt[i] = SPEED_W'(SPEED_MAX);
      end else if (val < -SPEED_MAX) begin
        wheel_nxt[i] = SPEED_W'(-SPEED_MAX);
      end else begin
        wheel_nxt[i] = SPEED_W'(val);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_rdy) begin
      out_valid_r <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (res_rdy) begin
      wheel_r  <= wheel_nxt;
      scaled_r <= res_data.scaled;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_wheel_front_left  = wheel_r[0];
  assign out_wheel_front_right = wheel_r[1];
  assign out_wheel_rear_right  = wheel_r[2];
  assign out_wheel_rear_left   = wheel_r[3];
  assign out_was_scaled        = scaled_r;

endmodule

>>> rtl/core/mwsm_mix.sv
// Command clamping, yaw lever-arm product and four-wheel mixing (two pipeline stages).
module mwsm_mix import mwsm_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      vld_i,
  output logic                      rdy_o,
  input  logic signed [SPEED_W-1:0] lat_i,
  input  logic signed [SPEED_W-1:0] fwd_i,
  input  logic signed [SPEED_W-1:0] yaw_i,
  input  logic [CFG_W-1:0]          max_lat_i,
  input  logic [CFG_W-1:0]          max_fwd_i,
  input  logic [CFG_W-1:0]          ctr_dist_i,
  output logic                      vld_o,
  input  logic                      rdy_i,
  output mix_t                      mix_o
);

  // Symmetric clamp to +/- lim
  function automatic logic signed [SPEED_W-1:0] clamp_sym(
    input logic signed [SPEED_W-1:0] v,
    input logic [CFG_W-1:0]          lim
  );
    logic signed [CMP_W-1:0] vx;
    logic signed [CMP_W-1:0] hi;
    logic signed [CMP_W-1:0] lo;
    logic signed [CMP_W-1:0] res;
    vx = CMP_W'(v);
    hi = CMP_W'($signed({1'b0, lim}));
    lo = -hi;
    if (vx > hi) begin
      res = hi;
    end else if (vx < lo) begin
      res = lo;
    end else begin
      res = vx;
    end
    return SPEED_W'(res);
  endfunction

  logic                      vld_a_r, vld_b_r;
  logic                      adv_a, adv_b;
  logic signed [SPEED_W-1:0] lat_r, fwd_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [PROD_W-1:0]  prod_nxt;
  mix_t                      mix_r, mix_nxt;

  // Stage handshake
  assign adv_b = !vld_b_r || rdy_i;
  assign adv_a = !vld_a_r || adv_b;
  assign rdy_o = adv_a;
  assign vld_o = vld_b_r;
  assign mix_o = mix_r;

  // Stage A: yaw times lever arm
  always_comb begin
    logic signed [PROD_W-1:0] yaw_x;
    logic signed [PROD_W-1:0] dist_x;
    yaw_x    = PROD_W'(yaw_i);
    dist_x   = PROD_W'($signed({1'b0, ctr_dist_i}));
    prod_nxt = yaw_x * dist_x;
  end

  // Stage B: scale back to Q4.11 (truncate toward zero) and mix
  always_comb begin
    logic signed [PROD_W-1:0]  biased;
    logic signed [ROT_W-1:0]   rot;
    logic signed [WHEEL_W-1:0] lx, fx, rx;
    biased = prod_r + (prod_r[PROD_W-1] ? PROD_W'(FRAC_MASK) : PROD_W'(0));
    rot    = ROT_W'(biased >>> FRAC_BITS);
    lx     = WHEEL_W'(lat_r);
    fx     = WHEEL_W'(fwd_r);
    rx     = WHEEL_W'(rot);
    mix_nxt.wheel[0] =  lx - fx - rx;
    mix_nxt.wheel[1] =  lx + fx - rx;
    mix_nxt.wheel[2] = -lx + fx - rx;
    mix_nxt.wheel[3] = -lx - fx - rx;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      if (adv_a) begin
        vld_a_r <= vld_i;
      end
      if (adv_b) begin
        vld_b_r <= vld_a_r;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (adv_a) begin
      lat_r  <= clamp_sym(lat_i, max_lat_i);
      fwd_r  <= clamp_sym(fwd_i, max_fwd_i);
      prod_r <= prod_nxt;
    end
    if (adv_b) begin
      mix_r <= mix_nxt;
    end
  end

endmodule

>>> rtl/core/mwsm_peak.sv
// Wheel magnitudes, peak search, limit compare and divider numerators (two pipeline stages).
module mwsm_peak import mwsm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             vld_i,
  output logic             rdy_o,
  input  mix_t             mix_i,
  input  logic [CFG_W-1:0] lim_i,
  output logic             vld_o,
  input  logic             rdy_i,
  output num_t             num_o
);

  logic                               vld_c_r, vld_d_r;
  logic                               adv_c, adv_d;
  logic [NUM_WHEELS-1:0][MAG_W-1:0]   mag_r, mag_nxt;
  logic [NUM_WHEELS-1:0]              neg_r, neg_nxt;
  num_t                               num_r, num_nxt;

  // Stage handshake
  assign adv_d = !vld_d_r || rdy_i;
  assign adv_c = !vld_c_r || adv_d;
  assign rdy_o = adv_c;
  assign vld_o = vld_d_r;
  assign num_o = num_r;

  // Stage C: sign and magnitude of each wheel
  always_comb begin
    logic signed [WHEEL_W-1:0] w;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      w          = $signed(mix_i.wheel[i]);
      neg_nxt[i] = w[WHEEL_W-1];
      mag_nxt[i] = neg_nxt[i] ? MAG_W'(-w) : MAG_W'(w);
    end
  end

  // Stage D: peak over four wheels, limit compare, numerators mag * limit
  always_comb begin
    logic [MAG_W-1:0] m01, m23;
    m01 = (mag_r[0] > mag_r[1]) ? mag_r[0] : mag_r[1];
    m23 = (mag_r[2] > mag_r[3]) ? mag_r[2] : mag_r[3];
    num_nxt.peak   = (m01 > m23) ? m01 : m23;
    num_nxt.scaled = num_nxt.peak > MAG_W'(lim_i);
    num_nxt.mag    = mag_r;
    num_nxt.neg    = neg_r;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      num_nxt.num[i] = NUM_W'(mag_r[i]) * NUM_W'(lim_i);
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_c_r <= 1'b0;
      vld_d_r <= 1'b0;
    end else begin
      if (adv_c) begin
        vld_c_r <= vld_i;
      end
      if (adv_d) begin
        vld_d_r <= vld_c_r;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (adv_c) begin
      mag_r <= mag_nxt;
      neg_r <= neg_nxt;
    end
    if (adv_d) begin
      num_r <= num_nxt;
    end
  end

endmodule

>>> rtl/core/mwsm_div.sv
// Pipelined restoring divider: four quotients mag*limit/peak, three bits per stage.
module mwsm_div import mwsm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic vld_i,
  output logic rdy_o,
  input  num_t num_i,
  output logic vld_o,
  input  logic rdy_i,
  output res_t res_o
);

  typedef struct packed {
    logic [NUM_WHEELS-1:0][REM_W-1:0] rem;
    logic [NUM_WHEELS-1:0][QUO_W-1:0] low;
    logic [NUM_WHEELS-1:0][QUO_W-1:0] quo;
    logic [NUM_WHEELS-1:0][MAG_W-1:0] mag;
    logic [NUM_WHEELS-1:0]            neg;
    logic [MAG_W-1:0]                 peak;
    logic                             scaled;
  } div_stage_t;

  localparam int LAST = DIV_STAGES - 1;

  div_stage_t            st_r     [DIV_STAGES];
  div_stage_t            st_nxt   [DIV_STAGES];
  div_stage_t            stage_in [DIV_STAGES];
  logic [DIV_STAGES-1:0] vld_r;
  logic [DIV_STAGES-1:0] vld_in;
  logic [DIV_STAGES-1:0] adv;

  // Stage handshake, back to front
  always_comb begin
    adv[LAST] = !vld_r[LAST] || rdy_i;
    for (int s = LAST - 1; s >= 0; s--) begin
      adv[s] = !vld_r[s] || adv[s+1];
    end
  end

  assign vld_in = {vld_r[DIV_STAGES-2:0], vld_i};
  assign rdy_o  = adv[0];
  assign vld_o  = vld_r[LAST];

  assign res_o.quo    = st_r[LAST].quo;
  assign res_o.mag    = st_r[LAST].mag;
  assign res_o.neg    = st_r[LAST].neg;
  assign res_o.scaled = st_r[LAST].scaled;

  // Divide steps; quotient fits QUO_W bits since mag <= peak and limit < 2^QUO_W,
  // so the top part of the numerator is already below the divisor
  always_comb begin
    div_stage_t       cur;
    logic [REM_W-1:0] trial;
    logic [REM_W-1:0] dvs;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      stage_in[0].rem[i] = REM_W'(num_i.num[i] >> QUO_W);
      stage_in[0].low[i] = num_i.num[i][QUO_W-1:0];
      stage_in[0].quo[i] = '0;
    end
    stage_in[0].mag    = num_i.mag;
    stage_in[0].neg    = num_i.neg;
    stage_in[0].peak   = num_i.peak;
    stage_in[0].scaled = num_i.scaled;
    for (int s = 1; s < DIV_STAGES; s++) begin
      stage_in[s] = st_r[s-1];
    end
    for (int s = 0; s < DIV_STAGES; s++) begin
      cur = stage_in[s];
      dvs = REM_W'(cur.peak);
      for (int j = 0; j < DIV_STEP; j++) begin
        for (int i = 0; i < NUM_WHEELS; i++) begin
          trial      = {cur.rem[i][REM_W-2:0], cur.low[i][QUO_W-1]};
          cur.low[i] = {cur.low[i][QUO_W-2:0], 1'b0};
          if (trial >= dvs) begin
            cur.rem[i] = trial - dvs;
            cur.quo[i] = {cur.quo[i][QUO_W-2:0], 1'b1};
          end else begin
            cur.rem[i] = trial;
            cur.quo[i] = {cur.quo[i][QUO_W-2:0], 1'b0};
          end
        end
      end
      st_nxt[s] = cur;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        if (adv[s]) begin
          vld_r[s] <= vld_in[s];
        end
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (adv[s]) begin
        st_r[s] <= st_nxt[s];
      end
    end
  end

  // Partial remainder always stays below a nonzero divisor
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_rem_chk
    a_rem_below_peak: assert property (@(posedge clk) disable iff (!rst_n)
      vld_r[s] && (st_r[s].peak != '0) |->
        (st_r[s].rem[0] < REM_W'(st_r[s].peak)) && (st_r[s].rem[1] < REM_W'(st_r[s].peak)) &&
        (st_r[s].rem[2] < REM_W'(st_r[s].peak)) && (st_r[s].rem[3] < REM_W'(st_r[s].peak)))
      else $error("divider remainder not below divisor");
  end

  // A scaled wheel never reaches the peak it was divided by
  a_quo_below_peak: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LAST] && st_r[LAST].scaled |->
      (MAG_W'(st_r[LAST].quo[0]) < st_r[LAST].peak) &&
      (MAG_W'(st_r[LAST].quo[1]) < st_r[LAST].peak) &&
      (MAG_W'(st_r[LAST].quo[2]) < st_r[LAST].peak) &&
      (MAG_W'(st_r[LAST].quo[3]) < st_r[LAST].peak))
    else $error("scaled quotient not below peak");

  // An accepted transfer occupies the first stage next cycle
  a_enter_first: assert property (@(posedge clk) disable iff (!rst_n)
    vld_i && rdy_o |=> vld_r[0])
    else $error("accepted operands lost at divider entry");

endmodule
